FILE: hdl/running_mean_covariance_unit_defines.svh
// Assertion macros for the running mean and covariance unit.
// Included by the checker; needs nothing else.
`ifndef RUNNING_MEAN_COVARIANCE_UNIT_DEFINES_SVH
`define RUNNING_MEAN_COVARIANCE_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define RMC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("rmc check failed: next-cycle consequence");

// Consequent must hold in the same cycle as the antecedent.
`define RMC_ASSERT_NOW(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("rmc check failed: same-cycle consequence");

`endif

FILE: hdl/rmc_pkg.sv
// Shared types, codes and helpers of the running mean and covariance unit.
// No dependencies.
`timescale 1ns / 1ps
package rmc_pkg;
	localparam int unsigned MAX_FEATURES_DEF = 8;
	localparam int unsigned COUNT_BITS_DEF   = 32;

	localparam int VAL_W  = 23;
	localparam int IN_W   = 24;
	localparam int PROD_W = 48;
	localparam int COV_W  = 50;
	localparam int NUM_W  = 51;

	localparam logic [2:0] FN_MEAN    = 3'd0;
	localparam logic [2:0] FN_COV     = 3'd1;
	localparam logic [2:0] FN_RD_MEAN = 3'd2;
	localparam logic [2:0] FN_RD_COV  = 3'd3;
	localparam logic [2:0] FN_CLEAR   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EVENT = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_RDCOV, S_MGO, S_MWAIT, S_DK, S_CRD, S_CMUL, S_CSUB, S_CDIV, S_DONE
	} seq_state_t;

	// Absolute value with the most negative code saturated.
	function automatic logic [VAL_W-1:0] abs_sat(input logic signed [IN_W-1:0] v);
		logic signed [IN_W-1:0] n;
		n = -v;
		if (v == {1'b1, {(IN_W-1){1'b0}}}) return {VAL_W{1'b1}};
		else if (v < 0) return n[VAL_W-1:0];
		else return v[VAL_W-1:0];
	endfunction
endpackage

FILE: hdl/rmc_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rmc_pkg.
`timescale 1ns / 1ps
module rmc_div import rmc_pkg::*; #(
	parameter int unsigned CB = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] numer,
	input  logic [CB-1:0]           denom,
	output logic                    done,
	output logic signed [NUM_W-1:0] quot
);
	localparam int SW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] mag_q;
	logic [CB-1:0]    rem_q;
	logic [CB-1:0]    den_q;
	logic             neg_q;
	logic [SW-1:0]    step_q;
	logic             run_q;
	logic             done_q;
	logic [CB:0]      trial;
	logic             fits;
	logic [NUM_W-1:0] nmag;

	// Shift in the next dividend bit and try the subtract.
	assign trial = {rem_q, mag_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign nmag  = -numer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= SW'(NUM_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == SW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold operands and advance the restoring steps.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= numer[NUM_W-1] ? nmag : numer;
			neg_q <= numer[NUM_W-1];
			den_q <= denom;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? CB'(trial - {1'b0, den_q}) : trial[CB-1:0];
			mag_q <= {mag_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(mag_q) : $signed(mag_q);
endmodule

FILE: hdl/running_mean_covariance_unit.sv
// Running mean and covariance unit: absolute feature values, two passes.
// Reads, clears and plain samples answer in the cycle after acceptance; a
// covariance read first passes through the registered store read. An event
// completion runs through the one-bit-per-cycle divider shared by all entries.
// Throughput: one transaction per cycle when no event completes; a covariance read
// holds busy for one cycle; results cannot stall.
// Reset clears counters, means and covariance valid bits at once; no sweep.
`timescale 1ns / 1ps
module running_mean_covariance_unit import rmc_pkg::*; #(
	parameter int unsigned MAX_FEATURES = MAX_FEATURES_DEF,
	parameter int unsigned COUNT_BITS   = COUNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              func,
	input  logic [2:0]              feature_index,
	input  logic [2:0]              column_index,
	input  logic signed [IN_W-1:0]  feature_value,
	input  logic                    cfg_we,
	input  logic [3:0]              cfg_data,
	output logic                    done,
	output logic signed [COV_W-1:0] read_value,
	output logic [1:0]              status,
	output logic [31:0]             event_count
);
	localparam int IW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int FW = $clog2(MAX_FEATURES + 1);
	localparam int CD = MAX_FEATURES * MAX_FEATURES;
	localparam int CA = (CD > 1) ? $clog2(CD) : 1;

	seq_state_t state_q, state_d;

	logic [3:0]             fiu_q;
	logic [FW-1:0]          f_eff;
	logic [FW-1:0]          k_q, l_q;
	logic [COUNT_BITS-1:0]  mean_cnt_q, cov_cnt_q;
	logic                   pass_cov_q;
	logic [VAL_W-1:0]       mean_q [MAX_FEATURES];
	logic [VAL_W-1:0]       buf_q  [MAX_FEATURES];
	logic [CD-1:0]          cov_vld_q;
	logic                   rd_vld_q;
	logic signed [COV_W-1:0] cov_mem [CD];
	logic signed [COV_W-1:0] mem_rdata_q;

	logic                   done_q;
	logic signed [COV_W-1:0] rv_q;
	logic [1:0]             status_q;
	logic [31:0]            cnt_q;

	logic signed [IN_W-1:0]   dk_q, dl_q, diff;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [COV_W-1:0]  cov_q;

	logic                   accept, row_ok, col_ok, last;
	logic [IW-1:0]          row_idx, col_idx, k_idx, l_idx, rd_idx;
	logic                   k_last, l_last;
	logic                   mem_re, mem_we;
	logic [CA-1:0]          mem_raddr, mem_waddr;
	logic signed [COV_W-1:0] mem_wdata;
	logic                   div_start, div_done;
	logic signed [NUM_W-1:0] div_num, div_quot;
	logic [COUNT_BITS-1:0]  div_den;

	// Clamp the feature count to the supported range.
	always_comb begin
		if (fiu_q == 4'd0) f_eff = FW'(1);
		else if (32'(fiu_q) > MAX_FEATURES) f_eff = FW'(MAX_FEATURES);
		else f_eff = FW'(fiu_q);
	end

	assign accept  = start && (state_q == S_IDLE);
	assign busy    = (state_q != S_IDLE);
	assign row_ok  = 32'(feature_index) < 32'(f_eff);
	assign col_ok  = 32'(column_index) < 32'(f_eff);
	assign last    = 32'(feature_index) == 32'(f_eff) - 32'd1;
	assign row_idx = IW'(feature_index);
	assign col_idx = IW'(column_index);
	assign k_idx   = k_q[IW-1:0];
	assign l_idx   = l_q[IW-1:0];
	assign k_last  = k_q == f_eff - 1'b1;
	assign l_last  = l_q == f_eff - 1'b1;
	assign div_den = pass_cov_q ? cov_cnt_q : mean_cnt_q;

	// Deviation of the buffered sample from its mean at the selected slot.
	assign diff = $signed({1'b0, buf_q[rd_idx]}) - $signed({1'b0, mean_q[rd_idx]});

	// Next state and per-state control.
	always_comb begin
		state_d   = state_q;
		rd_idx    = row_idx;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = CA'(32'(row_idx) * MAX_FEATURES + 32'(col_idx));
		mem_waddr = CA'(32'(k_idx) * MAX_FEATURES + 32'(l_idx));
		mem_wdata = COV_W'(NUM_W'(cov_q) + div_quot);
		div_start = 1'b0;
		div_num   = NUM_W'(diff);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (func)
						FN_MEAN: if (row_ok && last) state_d = S_MGO;
						FN_COV:  if (row_ok && last) state_d = S_DK;
						FN_RD_COV: begin
							if (row_ok && col_ok) begin
								mem_re  = 1'b1;
								state_d = S_RDCOV;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RDCOV: state_d = S_IDLE;
			S_MGO: begin
				rd_idx    = k_idx;
				div_start = 1'b1;
				state_d   = S_MWAIT;
			end
			S_MWAIT: if (div_done) state_d = k_last ? S_DONE : S_MGO;
			S_DK: begin
				rd_idx  = k_idx;
				state_d = S_CRD;
			end
			S_CRD: begin
				rd_idx    = l_idx;
				mem_re    = 1'b1;
				mem_raddr = CA'(32'(k_idx) * MAX_FEATURES + 32'(l_idx));
				state_d   = S_CMUL;
			end
			S_CMUL: state_d = S_CSUB;
			S_CSUB: begin
				div_start = 1'b1;
				div_num   = NUM_W'(prod_q) - NUM_W'(cov_q);
				state_d   = S_CDIV;
			end
			S_CDIV: begin
				if (div_done) begin
					mem_we = 1'b1;
					if (l_last) state_d = k_last ? S_DONE : S_DK;
					else state_d = S_CRD;
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control state, counters, means and results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fiu_q      <= 4'd1;
			k_q        <= '0;
			l_q        <= '0;
			mean_cnt_q <= '0;
			cov_cnt_q  <= '0;
			pass_cov_q <= 1'b0;
			cov_vld_q  <= '0;
			rd_vld_q   <= 1'b0;
			done_q     <= 1'b0;
			rv_q       <= '0;
			status_q   <= ST_OK;
			cnt_q      <= '0;
			for (int i = 0; i < MAX_FEATURES; i++) mean_q[i] <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) fiu_q <= cfg_data;
			if (mem_re) rd_vld_q <= cov_vld_q[mem_raddr];
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rv_q     <= '0;
						status_q <= ST_OK;
						done_q   <= 1'b1;
						case (func)
							FN_MEAN, FN_COV: begin
								cnt_q <= 32'((func == FN_MEAN) ? mean_cnt_q : cov_cnt_q);
								if (!row_ok) status_q <= ST_RANGE;
								else if (last) begin
									done_q     <= 1'b0;
									k_q        <= '0;
									l_q        <= '0;
									pass_cov_q <= (func == FN_COV);
									if (func == FN_MEAN) begin
										if (!(&mean_cnt_q)) mean_cnt_q <= mean_cnt_q + 1'b1;
									end else begin
										if (!(&cov_cnt_q)) cov_cnt_q <= cov_cnt_q + 1'b1;
									end
								end
							end
							FN_RD_MEAN: begin
								cnt_q <= 32'(mean_cnt_q);
								if (row_ok) rv_q <= COV_W'(mean_q[rd_idx]);
								else status_q <= ST_RANGE;
							end
							FN_RD_COV: begin
								cnt_q <= 32'(cov_cnt_q);
								if (row_ok && col_ok) done_q <= 1'b0;
								else status_q <= ST_RANGE;
							end
							FN_CLEAR: begin
								cnt_q      <= '0;
								mean_cnt_q <= '0;
								cov_cnt_q  <= '0;
								cov_vld_q  <= '0;
								for (int i = 0; i < MAX_FEATURES; i++) mean_q[i] <= '0;
							end
							default: begin
								cnt_q    <= '0;
								status_q <= ST_RANGE;
							end
						endcase
					end
				end
				S_RDCOV: begin
					done_q <= 1'b1;
					rv_q   <= rd_vld_q ? mem_rdata_q : '0;
				end
				S_MWAIT: begin
					if (div_done) begin
						mean_q[k_idx] <= VAL_W'(NUM_W'($signed({1'b0, mean_q[k_idx]})) + div_quot);
						if (!k_last) k_q <= k_q + 1'b1;
					end
				end
				S_CDIV: begin
					if (div_done) begin
						cov_vld_q[mem_waddr] <= 1'b1;
						if (l_last) begin
							l_q <= '0;
							if (!k_last) k_q <= k_q + 1'b1;
						end else begin
							l_q <= l_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					done_q   <= 1'b1;
					rv_q     <= '0;
					status_q <= ST_EVENT;
					cnt_q    <= 32'(pass_cov_q ? cov_cnt_q : mean_cnt_q);
				end
				default: ;
			endcase
		end
	end

	// Event buffer and arithmetic operands.
	always_ff @(posedge clk) begin
		if (accept && func == FN_CLEAR) begin
			for (int i = 0; i < MAX_FEATURES; i++) buf_q[i] <= '0;
		end else if (accept && (func == FN_MEAN || func == FN_COV) && row_ok) begin
			buf_q[row_idx] <= abs_sat(feature_value);
		end
		if (state_q == S_DK) dk_q <= diff;
		if (state_q == S_CRD) dl_q <= diff;
		if (state_q == S_CMUL) begin
			prod_q <= dk_q * dl_q;
			cov_q  <= rd_vld_q ? mem_rdata_q : '0;
		end
	end

	// Covariance store, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) cov_mem[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rdata_q <= cov_mem[mem_raddr];
	end

	rmc_div #(.CB(COUNT_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_num),
		.denom  (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign done        = done_q;
	assign read_value  = rv_q;
	assign status      = status_q;
	assign event_count = cnt_q;
endmodule

FILE: hdl/rmc_checker.sv
// Port-level checks for the running mean and covariance unit, bound to the top.
// Depends on rmc_pkg and running_mean_covariance_unit_defines.svh.
`timescale 1ns / 1ps
`include "running_mean_covariance_unit_defines.svh"
module rmc_checker import rmc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [2:0]        func,
	input logic              done,
	input logic [COV_W-1:0]  read_value,
	input logic [1:0]        status,
	input logic [31:0]       event_count
);
	// Every result carries a defined status code.
	`RMC_ASSERT_NOW(a_status_code, clk, arst_n, done, (status == ST_OK) || (status == ST_EVENT) || (status == ST_RANGE))
	// A clear transaction answers at once with zero count.
	`RMC_ASSERT_NEXT(a_clear_resp, clk, arst_n, start && !busy && func == FN_CLEAR, done && status == ST_OK && event_count == 32'd0)
	// An unknown function is flagged in the next cycle.
	`RMC_ASSERT_NEXT(a_bad_func, clk, arst_n, start && !busy && func > FN_CLEAR, done && status == ST_RANGE && read_value == '0)
	// An event completion returns no read data.
	`RMC_ASSERT_NOW(a_event_zero, clk, arst_n, done && status == ST_EVENT, read_value == '0)
endmodule

bind running_mean_covariance_unit rmc_checker u_rmc_checker (.*);

FILE: bench/running_mean_covariance_unit_test.sv
// Self-checking testbench for the running mean and covariance unit.
// Depends on rmc_pkg and running_mean_covariance_unit; runs on its own.
`timescale 1ns / 1ps

// Expected outcome of one transaction
typedef struct {
	logic [2:0]  func;
	logic [49:0] read_value;
	logic [1:0]  status;
	logic [31:0] event_count;
} rmc_outcome_t;

class rmc_scoreboard;
	int unsigned features;
	longint event_buf[8];
	longint means[8];
	longint covs[64];
	longint unsigned mean_n;
	longint unsigned cov_n;
	rmc_outcome_t pending_q[$];
	int errors;
	int events_seen;
	int reads_seen;

	function void clear_stores();
		for (int i = 0; i < 8; i++) begin
			event_buf[i] = 0;
			means[i] = 0;
		end
		for (int i = 0; i < 64; i++) covs[i] = 0;
		mean_n = 0;
		cov_n = 0;
	endfunction

	function void init();
		features = 1;
		errors = 0;
		events_seen = 0;
		reads_seen = 0;
		clear_stores();
	endfunction

	// Clamp the register value to the range that takes effect
	function void set_features(logic [3:0] v);
		features = (v == 0) ? 1 : (v > 8) ? 8 : v;
	endfunction

	function longint magnitude(logic signed [23:0] v);
		longint x;
		x = v;
		if (x < 0) x = -x;
		if (x > 8388607) x = 8388607;
		return x;
	endfunction

	// Advance the model state for one accepted transaction, queue its outcome
	function void note(logic [2:0] fn, logic [2:0] row, logic [2:0] col,
			logic signed [23:0] val);
		rmc_outcome_t o;
		longint n, dk, dl, rv;
		o.func = fn;
		rv = 0;
		o.status = rmc_pkg::ST_OK;
		o.event_count = 0;
		case (fn)
			rmc_pkg::FN_MEAN, rmc_pkg::FN_COV: begin
				o.event_count = 32'((fn == rmc_pkg::FN_MEAN) ? mean_n : cov_n);
				if (row >= features) o.status = rmc_pkg::ST_RANGE;
				else begin
					event_buf[row] = magnitude(val);
					if (row == features - 1) begin
						o.status = rmc_pkg::ST_EVENT;
						events_seen++;
						if (fn == rmc_pkg::FN_MEAN) begin
							if (mean_n < 64'hFFFF_FFFF) mean_n++;
							n = mean_n;
							for (int i = 0; i < features; i++)
								means[i] += (event_buf[i] - means[i]) / n;
							o.event_count = 32'(mean_n);
						end else begin
							if (cov_n < 64'hFFFF_FFFF) cov_n++;
							n = cov_n;
							for (int k = 0; k < features; k++) begin
								dk = event_buf[k] - means[k];
								for (int l = 0; l < features; l++) begin
									dl = event_buf[l] - means[l];
									covs[k*8+l] += (dk * dl - covs[k*8+l]) / n;
								end
							end
							o.event_count = 32'(cov_n);
						end
					end
				end
			end
			rmc_pkg::FN_RD_MEAN: begin
				o.event_count = 32'(mean_n);
				reads_seen++;
				if (row >= features) o.status = rmc_pkg::ST_RANGE;
				else rv = means[row];
			end
			rmc_pkg::FN_RD_COV: begin
				o.event_count = 32'(cov_n);
				reads_seen++;
				if (row >= features || col >= features) o.status = rmc_pkg::ST_RANGE;
				else rv = covs[row*8+col];
			end
			rmc_pkg::FN_CLEAR: clear_stores();
			default: o.status = rmc_pkg::ST_RANGE;
		endcase
		o.read_value = rv[49:0];
		pending_q.push_back(o);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want, logic [2:0] fn);
		$display("mismatch: %s got %0h want %0h (func %0d)", what, got, want, fn);
		errors++;
	endtask

	// Compare one result with the oldest outstanding transaction
	task check(logic [49:0] rv, logic [1:0] st, logic [31:0] cnt);
		rmc_outcome_t o;
		if (pending_q.size() == 0) begin
			$display("mismatch: result with no transaction outstanding");
			errors++;
		end else begin
			o = pending_q.pop_front();
			if (rv !== o.read_value) report("read_value", 64'(rv), 64'(o.read_value), o.func);
			if (st !== o.status) report("status", 64'(st), 64'(o.status), o.func);
			if (cnt !== o.event_count)
				report("event_count", 64'(cnt), 64'(o.event_count), o.func);
		end
	endtask
endclass

module running_mean_covariance_unit_test;
	import rmc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] func;
	logic [2:0] feature_index;
	logic [2:0] column_index;
	logic signed [23:0] feature_value;
	logic cfg_we;
	logic [3:0] cfg_data;
	logic done;
	logic signed [49:0] read_value;
	logic [1:0] status;
	logic [31:0] event_count;

	rmc_scoreboard sb;
	int items_sent;
	int idle_pct;
	int stall_cycles;

	running_mean_covariance_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .feature_index(feature_index), .column_index(column_index),
		.feature_value(feature_value), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.done(done), .read_value(read_value), .status(status),
		.event_count(event_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Check results, record accepted transactions and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check(read_value, status, event_count);
			if (start && !busy) sb.note(func, feature_index, column_index, feature_value);
			if (cfg_we) sb.set_features(cfg_data);
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) stall_cycles <= 0;
		else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d transactions outstanding",
				sb.pending_q.size());
			$display("[running_mean_covariance_unit] ERROR");
			$finish;
		end else stall_cycles <= stall_cycles + 1;
	end

	function logic signed [23:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 24'sh800000;
			1: return 24'sh7FFFFF;
			2: return 24'sh000000;
			3: return 24'sh800001;
			default: return 24'($urandom());
		endcase
	endfunction

	// Present one transaction and hold it until accepted
	task issue(logic [2:0] fn, logic [2:0] row, logic [2:0] col, logic signed [23:0] val);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		func = fn;
		feature_index = row;
		column_index = col;
		feature_value = val;
		start = 1'b1;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Drop start and hold until every outstanding transaction has returned
	task drain();
		@(negedge clk);
		start = 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task write_features(logic [3:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task full_event(logic [2:0] fn);
		for (int r = 0; r < sb.features; r++)
			issue(fn, 3'(r), 3'($urandom()), pick_value());
	endtask

	// Mostly complete events with random content, plus reads and noise
	task random_mix(int count);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: full_event(FN_MEAN);
				5, 6, 7, 8, 9, 10: full_event(FN_COV);
				11, 12: issue(FN_RD_MEAN, 3'($urandom()), 3'($urandom()), 24'($urandom()));
				13, 14, 15: issue(FN_RD_COV, 3'($urandom()), 3'($urandom()), 24'($urandom()));
				16: issue(3'($urandom_range(0, 1)), 3'($urandom()), 3'($urandom()),
					pick_value());
				17: issue(3'(FN_CLEAR + $urandom_range(1, 3)), 3'($urandom()),
					3'($urandom()), 24'($urandom()));
				18: if ($urandom_range(0, 3) == 0) issue(FN_CLEAR, 0, 0, 24'($urandom()));
				default: issue(3'($urandom_range(FN_RD_MEAN, FN_RD_COV)), 3'($urandom()),
					3'($urandom()), 0);
			endcase
		end
	endtask

	initial begin
		logic [3:0] settings[6];
		sb = new();
		sb.init();
		settings = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd5, 4'd2};
		items_sent = 0;
		idle_pct = 19;
		stall_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_MEAN;
		feature_index = 0;
		column_index = 0;
		feature_value = 0;
		cfg_we = 1'b0;
		cfg_data = 4'd1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: fill every buffer slot, then extremes and each function
		write_features(4'd8);
		for (int r = 0; r < 8; r++)
			issue(FN_MEAN, 3'(r), 0,
				(r == 0) ? 24'sh800000 : (r == 1) ? 24'sh7FFFFF : pick_value());
		issue(FN_COV, 0, 0, 24'sh800000);
		for (int r = 1; r < 8; r++) issue(FN_COV, 3'(r), 0, 24'sh7FFFFF);
		issue(FN_RD_MEAN, 0, 0, 0);
		issue(FN_RD_COV, 7, 7, 0);
		issue(FN_RD_COV, 0, 1, 0);
		issue(3'd7, 7, 7, 24'shFFFFFF);
		issue(FN_CLEAR, 0, 0, 0);
		issue(FN_RD_MEAN, 1, 0, 0);
		issue(FN_RD_COV, 1, 0, 0);

		// Random phases over several feature counts, extremes included
		random_mix(100);
		foreach (settings[i]) begin
			write_features(settings[i]);
			if (i == 2) idle_pct = 0;
			else idle_pct = 19;
			random_mix(100);
			if (i == 4) begin
				drain();
				issue(FN_RD_COV, 0, 0, 0);
			end
			// Sample and read at index 7, out of range below eight features
			issue(FN_MEAN, 7, 0, pick_value());
			issue(FN_RD_COV, 0, 7, 0);
		end
		write_features(4'd8);
		random_mix(60);

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d transactions, %0d completed events, %0d reads",
			items_sent, sb.events_seen, sb.reads_seen);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("[running_mean_covariance_unit] OK");
		end else begin
			$display("%0d mismatches, %0d left outstanding", sb.errors, sb.pending_q.size());
			$display("[running_mean_covariance_unit] ERROR");
		end
		$finish;
	end
endmodule

FILE: running_mean_covariance_unit.f
+incdir+hdl
hdl/rmc_pkg.sv
hdl/rmc_div.sv
hdl/running_mean_covariance_unit.sv
hdl/rmc_checker.sv
bench/running_mean_covariance_unit_test.sv
